// ===== sv/rne_pkg.sv =====
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, codes and the microcode table of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned ACC_W    = 12;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned STEP_COUNT = 13;
  localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3999;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
  localparam logic [SYM_W-1:0] SYM_M = 8'h4D;
  localparam logic [SYM_W-1:0] SYM_D = 8'h44;
  localparam logic [SYM_W-1:0] SYM_C = 8'h43;
  localparam logic [SYM_W-1:0] SYM_L = 8'h4C;
  localparam logic [SYM_W-1:0] SYM_X = 8'h58;
  localparam logic [SYM_W-1:0] SYM_V = 8'h56;
  localparam logic [SYM_W-1:0] SYM_I = 8'h49;

  typedef enum logic [1:0] {
    STATUS_CHAR  = 2'd0,
    STATUS_ZERO  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SPECIAL
  } state_t;

  // One control word: the weight tested and subtracted, the one or two
  // characters emitted on a match, and the jump target taken on a miss.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SYM_W-1:0]    first;
    logic [SYM_W-1:0]    second;
    logic                has_second;
    logic [STEP_W-1:0]   jump;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      4'd0:    w = '{10'd1000, SYM_M, SYM_NONE, 1'b0, 4'd1};
      4'd1:    w = '{10'd900,  SYM_C, SYM_M,    1'b1, 4'd2};
      4'd2:    w = '{10'd500,  SYM_D, SYM_NONE, 1'b0, 4'd3};
      4'd3:    w = '{10'd400,  SYM_C, SYM_D,    1'b1, 4'd4};
      4'd4:    w = '{10'd100,  SYM_C, SYM_NONE, 1'b0, 4'd5};
      4'd5:    w = '{10'd90,   SYM_X, SYM_C,    1'b1, 4'd6};
      4'd6:    w = '{10'd50,   SYM_L, SYM_NONE, 1'b0, 4'd7};
      4'd7:    w = '{10'd40,   SYM_X, SYM_L,    1'b1, 4'd8};
      4'd8:    w = '{10'd10,   SYM_X, SYM_NONE, 1'b0, 4'd9};
      4'd9:    w = '{10'd9,    SYM_I, SYM_X,    1'b1, 4'd10};
      4'd10:   w = '{10'd5,    SYM_V, SYM_NONE, 1'b0, 4'd11};
      4'd11:   w = '{10'd4,    SYM_I, SYM_V,    1'b1, 4'd12};
      4'd12:   w = '{10'd1,    SYM_I, SYM_NONE, 1'b0, 4'd12};
      default: w = '{10'd1,    SYM_I, SYM_NONE, 1'b0, 4'd12};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/rne_in_if.sv =====
// ----------------------------------------------------------------------------
// rne_in_if
// Input channel of the Roman numeral encoder: one signed integer.
// ----------------------------------------------------------------------------
interface rne_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/rne_out_if.sv =====
// ----------------------------------------------------------------------------
// rne_out_if
// Output channel of the Roman numeral encoder: one numeral character.
// ----------------------------------------------------------------------------
interface rne_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output symbol, output status, output last, input ready);
  modport sink   (input valid, input symbol, input status, input last, output ready);
endinterface

// ===== sv/roman_numeral_encoder.sv =====
// A value is accepted in the idle state; the sequencer then emits one character per free
// output slot and spends a step on each microcode word whose weight does not fit.
// One value is handled at a time; a new value is taken once the last character of the
// previous one sits in the output register.
// Reset clears the sequencer and the output valid flag; there is no clearing pass.
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a signed 16-bit integer into its Roman numeral, one ASCII character
// per output transaction, final one marked; zero and out-of-range get a status.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
  input  logic     clk,
  input  logic     rst,
  rne_in_if.sink   request,
  rne_out_if.source response
);
  import rne_pkg::*;

  // Sequencer state. The step counter addresses the microcode table; each
  // control word tests one weight against the remaining value.
  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                phase, phase_next;    // second character of a pair pending
  logic [ACC_W-1:0]    acc, acc_next;        // remaining value to encode
  status_t             code, code_next;      // status of a zero or out-of-range value

  // Output register. It decouples the sequencer from the consumer.
  logic                out_valid, out_valid_next;
  logic [SYM_W-1:0]    out_symbol, out_symbol_next;
  status_t             out_status, out_status_next;
  logic                out_last, out_last_next;

  ucode_t              uw;
  logic                slot_free;
  logic                fits;
  logic [ACC_W-1:0]    acc_sub;
  logic                acc_done;

  assign uw        = ucode_rom(step);
  assign slot_free = !out_valid || response.ready;
  assign fits      = acc >= {{(ACC_W-WEIGHT_W){1'b0}}, uw.weight};
  assign acc_sub   = acc - {{(ACC_W-WEIGHT_W){1'b0}}, uw.weight};
  assign acc_done  = (acc_sub == '0);

  assign request.ready   = (state == ST_IDLE);
  assign response.valid  = out_valid;
  assign response.symbol = out_symbol;
  assign response.status = out_status;
  assign response.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    acc        <= acc_next;
    code       <= code_next;
    out_symbol <= out_symbol_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    phase_next      = phase;
    acc_next        = acc;
    code_next       = code;
    out_valid_next  = out_valid && !response.ready;
    out_symbol_next = out_symbol;
    out_status_next = out_status;
    out_last_next   = out_last;

    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          // Negative values and values above the largest numeral get a single
          // out-of-range transaction; zero gets a single empty one.
          if (request.value[VALUE_W-1] || (request.value > MAX_VALUE)) begin
            state_next = ST_SPECIAL;
            code_next  = STATUS_RANGE;
          end else if (request.value == '0) begin
            state_next = ST_SPECIAL;
            code_next  = STATUS_ZERO;
          end else begin
            state_next = ST_RUN;
            acc_next   = request.value[ACC_W-1:0];
            step_next  = '0;
            phase_next = 1'b0;
          end
        end
      end

      ST_SPECIAL: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_symbol_next = SYM_NONE;
          out_status_next = code;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      ST_RUN: begin
        if (phase) begin
          // Second character of a subtractive pair; the weight comes off now.
          if (slot_free) begin
            out_valid_next  = 1'b1;
            out_symbol_next = uw.second;
            out_status_next = STATUS_CHAR;
            out_last_next   = acc_done;
            acc_next        = acc_sub;
            phase_next      = 1'b0;
            if (acc_done) begin
              state_next = ST_IDLE;
            end
          end
        end else if (!fits) begin
          // Conditional jump: this weight no longer fits, move to the next word.
          step_next = uw.jump;
        end else if (slot_free) begin
          out_valid_next  = 1'b1;
          out_symbol_next = uw.first;
          out_status_next = STATUS_CHAR;
          if (uw.has_second) begin
            out_last_next = 1'b0;
            phase_next    = 1'b1;
          end else begin
            out_last_next = acc_done;
            acc_next      = acc_sub;
            if (acc_done) begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The step counter never runs past the last control word while encoding.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step < STEP_W'(STEP_COUNT)))
    else $error("microcode step out of range");

  // While encoding, something is always left to encode.
  a_acc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (acc != '0))
    else $error("encoding with nothing left");

  // A character transaction always carries a real character.
  a_char_symbol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == STATUS_CHAR)) |-> (out_symbol != SYM_NONE))
    else $error("character transaction without a character");

  // A zero or out-of-range value ends in one marked transaction and idle.
  a_special_done: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SPECIAL) && slot_free) |=>
      ((state == ST_IDLE) && out_valid && out_last && (out_symbol == SYM_NONE)))
    else $error("special value not finished in one transaction");

  // Going idle from encoding always coincides with a final character.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && (state_next == ST_IDLE)) |=> (out_valid && out_last))
    else $error("run ended without a final character");

endmodule

// ===== tb/roman_numeral_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roman_numeral_checker
// Watches both channels of the Roman numeral encoder. It predicts the
// character run for every accepted value and compares each output
// transaction, field by field, with the oldest character still expected.
// ----------------------------------------------------------------------------
module roman_numeral_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [15:0]              in_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [rne_pkg::SYM_W-1:0] out_symbol,
  input  logic [1:0]               out_status,
  input  logic                     out_last,
  output int                       mismatches,
  output int                       outstanding
);
  import rne_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    status_t          status;
    logic             last;
  } numeral_char_t;

  // Weights in descending order with the text each one contributes.
  int unsigned numeral_weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  string       numeral_text   [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL",
                                       "X", "IX", "V", "IV", "I"};

  numeral_char_t expected_chars[$];
  int            fail_count    = 0;
  int            pending_count = 0;

  assign mismatches  = fail_count;
  assign outstanding = pending_count;

  // Appends the characters that one input value must produce.
  function automatic void spell_numeral(input logic [15:0] value);
    numeral_char_t run[$];
    numeral_char_t ch;
    int unsigned   remaining;
    if (value[15] || value > MAX_VALUE) begin
      expected_chars.push_back(numeral_char_t'{SYM_NONE, STATUS_RANGE, 1'b1});
      return;
    end
    if (value == '0) begin
      expected_chars.push_back(numeral_char_t'{SYM_NONE, STATUS_ZERO, 1'b1});
      return;
    end
    remaining = 32'(value);
    for (int s = 0; s < 13; s++) begin
      while (remaining >= numeral_weight[s]) begin
        for (int i = 0; i < numeral_text[s].len(); i++) begin
          ch.symbol = numeral_text[s][i];
          ch.status = STATUS_CHAR;
          ch.last   = 1'b0;
          run.push_back(ch);
        end
        remaining -= numeral_weight[s];
      end
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[k]) expected_chars.push_back(run[k]);
  endfunction

  always @(posedge clk) begin
    numeral_char_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected character symbol=%h status=%0d last=%b", $realtime,
                     out_symbol, out_status, out_last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_symbol !== want.symbol || out_status !== want.status ||
              out_last !== want.last) begin
            if (fail_count < 10)
              $display("%0t: expected symbol=%h status=%0d last=%b, %s=%h status=%0d last=%b",
                       $realtime, want.symbol, want.status, want.last, "got symbol",
                       out_symbol, out_status, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) spell_numeral(in_value);
      pending_count <= expected_chars.size();
    end
  end

endmodule

// ===== tb/roman_numeral_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_tb
// Drives integers into the Roman numeral encoder: a directed set of corner
// values first, then random values in several flow-control phases. The
// checker beside the block predicts and compares; this module decides the
// verdict.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_tb;
  import rne_pkg::*;

  logic clk = 1'b0;
  logic rst;

  // Percent chance per cycle that the sender holds back a transaction and
  // that the receiver drops ready. The main sequence changes them per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int mismatches;
  int outstanding;

  rne_in_if  req_if ();
  rne_out_if rsp_if ();

  roman_numeral_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (rsp_if)
  );

  roman_numeral_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req_if.valid),
    .in_ready    (req_if.ready),
    .in_value    (req_if.value),
    .out_valid   (rsp_if.valid),
    .out_ready   (rsp_if.ready),
    .out_symbol  (rsp_if.symbol),
    .out_status  (rsp_if.status),
    .out_last    (rsp_if.last),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver side. Ready is redrawn at every rising edge, so stalls land
  // anywhere inside a character run, including on its last character.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Presents one value and returns at the edge where it is accepted. Valid is
  // left high on return; the next call either replaces the value or lowers
  // valid for an idle cycle, so each edge sees at most one assignment.
  task automatic send_value(input logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= v;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Random values lean toward the legal range, where the interesting work
  // is, with a share of short numerals, long ones near the top of the range,
  // zero, too-large positives and fully random words that reach every bit.
  function automatic logic [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)      return 16'($urandom_range(3999, 1));
    else if (r < 67) return 16'($urandom_range(49, 1));
    else if (r < 75) return 16'($urandom_range(3999, 3000));
    else if (r < 80) return '0;
    else if (r < 88) return 16'($urandom_range(32767, 4000));
    else             return 16'($urandom());
  endfunction

  initial begin
    logic [15:0] corner_values [25];
    int          drain_cycles;
    // Edges of the legal range, a lone symbol of every weight, every
    // subtractive pair including four hundreds, the longest numeral, zero,
    // and out-of-range values on both sides.
    corner_values = '{16'd0, 16'd1, 16'd3, 16'd4, 16'd5, 16'd9, 16'd10, 16'd40, 16'd49,
                      16'd50, 16'd90, 16'd100, 16'd400, 16'd444, 16'd499, 16'd500,
                      16'd900, 16'd1000, 16'd1994, 16'd3888, 16'd3999, 16'd4000,
                      16'hFFFF, 16'h8000, 16'h7FFF};
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) send_value(corner_values[i]);

    // Seven phases of fifty values cycle through free flow, a slow sender,
    // a slow receiver and both lightly throttled; all but the last mode run
    // twice.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      repeat (50) send_value(pick_value());
    end
    req_if.valid <= 1'b0;

    // Let the receiver run freely, wait for the last run to come out, then
    // allow a full worst-case conversion time for anything extra to appear.
    recv_stall_pct = 0;
    drain_cycles   = 0;
    while (outstanding != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of all phases.
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
